@@ hw/rtl/wco_pkg.sv @@
// Shared constants and types for the wavetable cubic oscillator.
// No dependencies; every other file imports this package.
package wco_pkg;

    localparam int VOICES      = 16;
    localparam int VOICE_W     = 4;
    localparam int TABLE_DEPTH = 1024;
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);
    localparam int TIN_W       = 10;
    localparam int LEN_W       = 11;
    localparam int STEP_W      = 31;
    localparam int VAL_W       = 16;
    localparam int SMP_W       = 18;

    localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(1000);
    localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(4295);
    localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(1503238554);

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam int DIV_BITS  = 8;
    localparam int DIV_W     = 40;
    localparam int DIV_CYC   = DIV_W / DIV_BITS;
    localparam int DIV_DEN   = 6;

endpackage

@@ hw/rtl/wco_if.sv @@
// Handshake interfaces for the request and sample channels.
// Depends on wco_pkg for field widths.
interface wco_req_if import wco_pkg::*;;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [VOICE_W-1:0]  voice;
    logic [STEP_W-1:0]   phase_step;
    logic [TIN_W-1:0]    table_index;
    logic [VAL_W-1:0]    table_value;

    modport source (output valid, req_type, voice, phase_step, table_index, table_value,
                    input ready);
    modport sink   (input valid, req_type, voice, phase_step, table_index, table_value,
                    output ready);
endinterface

interface wco_smp_if import wco_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [VOICE_W-1:0]       voice_out;
    logic signed [SMP_W-1:0]  sample_out;

    modport source (output valid, voice_out, sample_out, input ready);
    modport sink   (input valid, voice_out, sample_out, output ready);
endinterface

@@ hw/rtl/wavetable_cubic_oscillator_unit.sv @@
// Top level of the wavetable cubic oscillator: phase memory, wave table,
// interpolation datapath and output register. Depends on wco_pkg and wco_if.
//
// Usage. Requests arrive on req. A table write (req_type one) is taken while
// the block is idle and gives no sample. A tick (req_type zero) advances the
// voice's phase and produces one sample on smp, tagged with the voice.
// A tick occupies the block from its transfer until the sample is loaded
// into the output register: one phase memory read, a 32 by 11 bit multiply,
// four reads of the single-port wave table, three multiplies and a divide by
// six that retires eight bits a cycle. A new request is taken only once the
// sample is loaded, so no tick or write is taken while a tick is in progress;
// table writes are taken at one per cycle while the block is idle.
// The output register decouples the sides: the next request is accepted while
// a sample still waits. If the receiver stalls and a second sample is ready,
// the datapath holds in its last step until the register frees.
// Reset clears all voice phases to zero and sets table_length to 1000; the
// wave table holds nothing until written and must be written before use.
// table_length is written through table_length_we and table_length_wdata;
// the user must write it only while the block is idle; the block itself does not enforce this.
module wavetable_cubic_oscillator_unit
    import wco_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               table_length_we,
    input  logic [LEN_W-1:0]   table_length_wdata,
    wco_req_if.sink            req,
    wco_smp_if.source          smp
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PHASE = 13'b0000000000010,
        S_IDX   = 13'b0000000000100,
        S_TB    = 13'b0000000001000,
        S_TC    = 13'b0000000010000,
        S_TD    = 13'b0000000100000,
        S_PQ    = 13'b0000001000000,
        S_T     = 13'b0000010000000,
        S_U     = 13'b0000100000000,
        S_S6    = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_Y     = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_eff;

    logic [31:0]        phase_mem [VOICES];
    logic [VOICES-1:0]  ph_vld_reg;
    logic [31:0]        ph_rd_reg;
    logic               ph_rd_vld_reg;
    logic [31:0]        ph_new;

    logic [VAL_W-1:0]   wt_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]   tbl_rd_reg;
    logic [TIDX_W-1:0]  tbl_raddr;
    logic               tbl_re;
    logic               tbl_we;

    logic [VOICE_W-1:0] voice_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_clamp;
    logic [42:0]        prod_reg;
    logic [TIDX_W-1:0]  idx;
    logic [TIDX_W-1:0]  last;
    logic [TIDX_W-1:0]  addr_a, addr_c, addr_d;
    logic [TIDX_W:0]    idx_p1, idx_p2;
    logic [VAL_W-1:0]   f_reg;
    logic [16:0]        g;

    logic [VAL_W-1:0]   a_reg, b_reg, c_reg;
    logic signed [19:0] p_reg, q_reg;
    logic signed [17:0] cb_reg;
    logic signed [19:0] ea, eb, ec, ed;
    logic signed [36:0] t_reg;
    logic signed [53:0] u_reg;
    logic signed [54:0] u_full;
    logic signed [20:0] cb6;
    logic signed [53:0] s6;

    logic [DIV_W-1:0]   div_w_reg, div_q_reg;
    logic [2:0]         div_r_reg;
    logic [2:0]         div_cnt_reg;
    logic [DIV_W-1:0]   div_q_next;
    logic [2:0]         div_r_next;
    logic signed [37:0] s32;
    logic signed [54:0] fs;
    logic signed [55:0] y_reg;
    logic signed [25:0] smp_w;
    logic signed [SMP_W-1:0] smp_sat;

    logic                    out_vld_reg;
    logic [VOICE_W-1:0]      out_voice_reg;
    logic signed [SMP_W-1:0] out_smp_reg;
    logic                    out_load;
    logic                    req_fire;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign len_eff = (len_reg == '0) ? LEN_W'(1) :
                     (len_reg > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_reg;

    assign step_clamp = (req.phase_step < STEP_MIN) ? STEP_MIN :
                        (req.phase_step > STEP_MAX) ? STEP_MAX : req.phase_step;

    assign ph_new = (ph_rd_vld_reg ? ph_rd_reg : 32'd0) + {1'b0, step_reg};

    assign idx    = prod_reg[32 +: TIDX_W];
    assign last   = TIDX_W'(len_eff - LEN_W'(1));
    assign addr_a = (idx == '0) ? '0 : idx - TIDX_W'(1);
    assign idx_p1 = {1'b0, idx} + (TIDX_W+1)'(1);
    assign idx_p2 = {1'b0, idx} + (TIDX_W+1)'(2);
    assign addr_c = (idx_p1 > {1'b0, last}) ? last : idx_p1[TIDX_W-1:0];
    assign addr_d = (idx_p2 > {1'b0, last}) ? last : idx_p2[TIDX_W-1:0];
    assign g      = 17'h10000 - {1'b0, f_reg};

    assign tbl_we = req_fire && (req.req_type == REQ_WRITE)
                    && ({1'b0, req.table_index} < (TIN_W+1)'(TABLE_DEPTH));

    always_comb
    begin
        tbl_re    = 1'b1;
        tbl_raddr = idx;
        unique case (state_reg)
            S_IDX:   tbl_raddr = addr_a;
            S_TB:    tbl_raddr = idx;
            S_TC:    tbl_raddr = addr_c;
            S_TD:    tbl_raddr = addr_d;
            default: tbl_re    = 1'b0;
        endcase
    end

    assign ea = $signed({4'b0, a_reg});
    assign eb = $signed({4'b0, b_reg});
    assign ec = $signed({4'b0, c_reg});
    assign ed = $signed({4'b0, tbl_rd_reg});

    assign u_full = t_reg * $signed({1'b0, g});
    assign cb6    = $signed({{3{cb_reg[17]}}, cb_reg}) * $signed(21'sd6);
    assign s6     = $signed({cb6[20], cb6, 32'b0}) - u_reg;

    always_comb
    begin
        logic [3:0] r4;
        logic [2:0] r;
        logic [DIV_W-1:0] qv;
        r  = div_r_reg;
        qv = div_q_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r4 = {r, div_w_reg[DIV_W-1-i]};
            qv = {qv[DIV_W-2:0], 1'b0};
            if (r4 >= 4'(DIV_DEN))
            begin
                r4    = r4 - 4'(DIV_DEN);
                qv[0] = 1'b1;
            end
            r = r4[2:0];
        end
        div_r_next = r;
        div_q_next = qv;
    end

    assign s32 = $signed(div_q_reg[37:0] - (38'd1 << 37));
    assign fs  = $signed({1'b0, f_reg}) * s32;

    assign smp_w   = $signed({y_reg[55], y_reg[55:31]}) - 26'sd65536;
    assign smp_sat = (smp_w < -26'sd131072) ? $signed(18'h20000) :
                     (smp_w >  26'sd131071) ?  18'sd131071 : smp_w[SMP_W-1:0];

    assign out_load = (state_reg == S_OUT) && (!out_vld_reg || smp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_TICK)
                    && ({1'b0, req.voice} < (VOICE_W+1)'(VOICES)))
                begin
                    state_next = S_PHASE;
                end
            end
            S_PHASE: state_next = S_IDX;
            S_IDX:   state_next = S_TB;
            S_TB:    state_next = S_TC;
            S_TC:    state_next = S_TD;
            S_TD:    state_next = S_PQ;
            S_PQ:    state_next = S_T;
            S_T:     state_next = S_U;
            S_U:     state_next = S_S6;
            S_S6:    state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == 3'(DIV_CYC - 1))
                begin
                    state_next = S_Y;
                end
            end
            S_Y:     state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= LEN_RESET;
            ph_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (table_length_we)
            begin
                len_reg <= table_length_wdata;
            end
            if (state_reg == S_PHASE)
            begin
                ph_vld_reg[voice_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (smp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            voice_reg     <= req.voice;
            step_reg      <= step_clamp;
            ph_rd_reg     <= phase_mem[req.voice];
            ph_rd_vld_reg <= ph_vld_reg[req.voice];
        end
        if (state_reg == S_PHASE)
        begin
            phase_mem[voice_reg] <= ph_new;
            prod_reg <= 43'(ph_new * {21'b0, len_eff});
        end
        if (tbl_we)
        begin
            wt_mem[req.table_index[TIDX_W-1:0]] <= req.table_value;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= wt_mem[tbl_raddr];
        end
        unique case (state_reg)
            S_IDX: f_reg <= prod_reg[31:16];
            S_TB:  a_reg <= tbl_rd_reg;
            S_TC:  b_reg <= tbl_rd_reg;
            S_TD:  c_reg <= tbl_rd_reg;
            S_PQ:
            begin
                p_reg  <= ed - ea - 20'sd3 * (ec - eb);
                q_reg  <= ed + 20'sd2 * ea - 20'sd3 * eb;
                cb_reg <= 18'(ec - eb);
            end
            S_T:   t_reg <= 37'(p_reg * $signed({1'b0, f_reg}))
                            + $signed({q_reg[19], q_reg, 16'b0});
            S_U:   u_reg <= u_full[53:0];
            S_S6:
            begin
                div_w_reg <= DIV_W'($signed({{2{s6[53]}}, s6[53:16]}))
                             + DIV_W'(40'hC0_0000_0000);
                div_q_reg <= '0;
                div_r_reg <= '0;
            end
            S_DIV:
            begin
                div_w_reg <= {div_w_reg[DIV_W-DIV_BITS-1:0], DIV_BITS'(0)};
                div_q_reg <= div_q_next;
                div_r_reg <= div_r_next;
            end
            S_Y:   y_reg <= $signed({8'b0, b_reg, 32'b0}) + 56'(fs);
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_voice_reg <= voice_reg;
            out_smp_reg   <= smp_sat;
        end
    end

    assign smp.valid      = out_vld_reg;
    assign smp.voice_out  = out_voice_reg;
    assign smp.sample_out = out_smp_reg;

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (state_reg == S_IDLE))
        else $error("table write outside idle");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg < 3'(DIV_CYC)))
        else $error("divider overran its step count");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_vld_reg)
        else $error("sample load did not set output valid");

    a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PHASE) |=> ph_vld_reg[$past(voice_reg)])
        else $error("phase write did not mark voice valid");

endmodule

@@ tb/sv/wco_checker.sv @@
`timescale 1ns / 100ps
// Checker for the wavetable cubic oscillator: watches the request, sample and
// table_length ports, predicts each sample and compares. Depends on wco_pkg, wco_if.
module wco_checker
    import wco_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             table_length_we,
    input  logic [LEN_W-1:0] table_length_wdata,
    wco_req_if               req,
    wco_smp_if               smp,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [VOICE_W-1:0]      voice_out;
        logic signed [SMP_W-1:0] sample_out;
    } sample_t;

    logic [31:0]      phase_mem [VOICES];
    logic [VAL_W-1:0] wave_mem  [TABLE_DEPTH];
    logic [LEN_W-1:0] length_reg;
    sample_t          exp_fifo [4096];
    logic [11:0]      wr_ptr;
    logic [11:0]      rd_ptr;
    int               fill_cnt;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint entry(longint k, longint len);
        if (k < 0)
            k = 0;
        if (k > len - 1)
            k = len - 1;
        return longint'(wave_mem[k]);
    endfunction

    function automatic sample_t interpolate(logic [VOICE_W-1:0] v, logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] st;
        logic [63:0]       prod;
        longint            len, idx, f, g, a, b, c, d, t, u, s6, s32, y, smp_val;
        sample_t           res;
        st = step;
        if (st < STEP_MIN)
            st = STEP_MIN;
        if (st > STEP_MAX)
            st = STEP_MAX;
        phase_mem[v] = phase_mem[v] + {1'b0, st};
        len = longint'(length_reg);
        if (len < 1)
            len = 1;
        if (len > TABLE_DEPTH)
            len = TABLE_DEPTH;
        prod = {32'd0, phase_mem[v]} * 64'(len);
        idx = longint'(prod[63:32]);
        f = longint'(prod[31:16]);
        g = 65536 - f;
        a = entry(idx - 1, len);
        b = entry(idx, len);
        c = entry(idx + 1, len);
        d = entry(idx + 2, len);
        t = (d - a - 3 * (c - b)) * f + (d + 2 * a - 3 * b) * 65536;
        u = t * g;
        s6 = 6 * (c - b) * 64'sd4294967296 - u;
        s32 = floor_div(s6, 6 * 65536);
        y = b * 64'sd4294967296 + f * s32;
        smp_val = floor_div(y, 64'sd2147483648) - 65536;
        if (smp_val < -131072)
            smp_val = -131072;
        if (smp_val > 131071)
            smp_val = 131071;
        res.voice_out = v;
        res.sample_out = SMP_W'(smp_val);
        return res;
    endfunction

    assign pending = fill_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        sample_t exp_s;
        if (!rst_n)
        begin
            for (int k = 0; k < VOICES; k++)
                phase_mem[k] = '0;
            length_reg = LEN_RESET;
            wr_ptr = '0;
            rd_ptr = '0;
            fill_cnt = 0;
            fail_count = 0;
        end
        else
        begin
            if (table_length_we)
                length_reg = table_length_wdata;
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_WRITE)
                    wave_mem[req.table_index] = req.table_value;
                else if (req.voice < VOICES)
                begin
                    exp_fifo[wr_ptr] = interpolate(req.voice, req.phase_step);
                    wr_ptr = wr_ptr + 12'd1;
                    fill_cnt++;
                end
            end
            if (smp.valid && smp.ready)
            begin
                if (fill_cnt == 0)
                begin
                    $error("unexpected sample: voice_out %0d sample_out %0d",
                           smp.voice_out, smp.sample_out);
                    fail_count++;
                end
                else
                begin
                    exp_s = exp_fifo[rd_ptr];
                    rd_ptr = rd_ptr + 12'd1;
                    fill_cnt--;
                    if (smp.voice_out !== exp_s.voice_out)
                    begin
                        $error("voice_out: expected %0d, actual %0d",
                               exp_s.voice_out, smp.voice_out);
                        fail_count++;
                    end
                    if (smp.sample_out !== exp_s.sample_out)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               exp_s.sample_out, smp.sample_out);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the oscillator testbench: clock, reset, stimulus and verdict.
// Depends on wco_pkg, wco_if, wco_checker and the oscillator RTL.
module tb;
    import wco_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;

    logic             clk;
    logic             rst_n;
    logic             table_length_we;
    logic [LEN_W-1:0] table_length_wdata;
    int               fail_count;
    int               pending;
    int               cycle_count;
    bit               no_idle;
    bit               hold_request;

    wco_req_if req_ch();
    wco_smp_if smp_ch();

    wavetable_cubic_oscillator_unit DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .table_length_we    (table_length_we),
        .table_length_wdata (table_length_wdata),
        .req                (req_ch),
        .smp                (smp_ch)
    );

    wco_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .table_length_we    (table_length_we),
        .table_length_wdata (table_length_wdata),
        .req                (req_ch),
        .smp                (smp_ch),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send(logic rt, logic [VOICE_W-1:0] v, logic [STEP_W-1:0] step,
                        logic [TIN_W-1:0] idx, logic [VAL_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.voice       <= v;
        req_ch.phase_step  <= step;
        req_ch.table_index <= idx;
        req_ch.table_value <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic tick(logic [VOICE_W-1:0] v, logic [STEP_W-1:0] step);
        send(REQ_TICK, v, step, TIN_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_length(logic [LEN_W-1:0] len);
        wait_drained();
        table_length_we    <= 1'b1;
        table_length_wdata <= len;
        @(posedge clk);
        table_length_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [STEP_W-1:0] rand_step();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return STEP_W'($urandom_range(0, 4294));
        if (sel == 1)
            return STEP_W'($urandom_range(1503238554, 32'h7fff_ffff));
        if (sel == 2)
            return STEP_W'($urandom);
        return STEP_W'($urandom_range(4295, 1503238554));
    endfunction

    task automatic random_phase(int count, logic [LEN_W-1:0] len);
        set_length(len);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                send(REQ_WRITE, VOICE_W'($urandom), STEP_W'($urandom),
                     TIN_W'($urandom), VAL_W'($urandom));
            else
                tick(VOICE_W'($urandom), rand_step());
        end
    endtask

    always
    begin
        int n;
        @(posedge clk);
        if (rst_n)
        begin
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_request)
            begin
                n = 300;
                hold_request = 1'b0;
            end
            if (n > 0)
            begin
                smp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            smp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(smp_ch.valid && smp_ch.ready))
                @(posedge clk);
        end
    end

    initial
    begin
        cycle_count        = 0;
        no_idle            = 1'b0;
        hold_request       = 1'b0;
        rst_n              = 1'b0;
        table_length_we    = 1'b0;
        table_length_wdata = LEN_RESET;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_TICK;
        req_ch.voice       = '0;
        req_ch.phase_step  = '0;
        req_ch.table_index = '0;
        req_ch.table_value = '0;
        smp_ch.ready       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        no_idle = 1'b1;
        for (int k = 0; k < TABLE_DEPTH; k++)
            send(REQ_WRITE, '0, '0, TIN_W'(k), (k % 2 == 0) ? VAL_W'(0) : VAL_W'(16'hffff));
        no_idle = 1'b0;

        tick(4'd0, '0);
        tick(4'd15, STEP_MIN);
        tick(4'd1, STEP_MAX);
        tick(4'd2, 31'h7fff_ffff);
        tick(4'd3, STEP_MIN - 1);
        tick(4'd4, STEP_MAX + 1);
        set_length(LEN_W'(1));
        tick(4'd5, STEP_MAX);
        tick(4'd5, 31'h7fff_ffff);
        set_length(LEN_W'(0));
        tick(4'd6, 31'h5555_5555);
        set_length(LEN_W'(2047));
        tick(4'd7, STEP_MAX);
        tick(4'd7, 31'h2aaa_aaaa);
        set_length(LEN_W'(TABLE_DEPTH));
        tick(4'd8, STEP_MAX);
        tick(4'd8, STEP_MAX);
        send(REQ_WRITE, '0, '0, 10'd1023, 16'h8000);
        send(REQ_WRITE, '0, '0, 10'd0, 16'hffff);
        tick(4'd8, STEP_MAX);
        tick(4'd9, STEP_MIN);

        random_phase(120, LEN_RESET);
        hold_request = 1'b1;
        no_idle = 1'b1;
        random_phase(80, LEN_W'($urandom_range(1, 1024)));
        no_idle = 1'b0;
        random_phase(60, LEN_W'(2));
        random_phase(120, LEN_W'(TABLE_DEPTH));
        random_phase(50, LEN_W'(0));
        random_phase(50, LEN_W'(2047));
        random_phase(60, LEN_W'(3));
        random_phase(150, LEN_W'($urandom_range(1, 2047)));

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
